// ===== rtl/contiguous_frame_allocator_unit_assert.svh =====
// Assertion macros for the contiguous frame allocator controller.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define CFA_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CFA_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfa_pkg.sv =====
// Shared types and constants of the contiguous frame allocator.
// Used by the configuration block, the controller and the top level.
package cfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;

  localparam int FRAME_W     = 20;
  localparam int COUNT_W     = 11;
  localparam int STATUS_W    = 3;
  localparam int REQ_W       = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - FRAME_W - STATUS_W;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // One frame of state map covers 2^14 two-bit entries.
  localparam int MAP_SHIFT = 14;

  // Per-frame state codes.
  typedef enum logic [1:0] {
    FS_ALLOC = 2'b00,
    FS_INACC = 2'b01,
    FS_HEAD  = 2'b10,
    FS_FREE  = 2'b11
  } fstate_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MARK    = 2'd2,
    REQ_INIT    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_ZERO_COUNT  = 3'd1,
    STAT_NO_FIT      = 3'd2,
    STAT_OUT_OF_POOL = 3'd3,
    STAT_NOT_HEAD    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE_FRAME    = 2'd0,
    REG_POOL_SIZE     = 2'd1,
    REG_RESERVE_START = 2'd2,
    REG_RESERVED_CNT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [FRAME_W-1:0] base_frame;
    logic [COUNT_W-1:0] pool_size;
    logic               reserve_at_start;
    logic [COUNT_W-1:0] reserved_frames;
  } cfg_t;

  localparam logic [FRAME_W-1:0] BASE_FRAME_RST      = '0;
  localparam logic [COUNT_W-1:0] POOL_SIZE_RST       = 11'd1024;
  localparam logic               RESERVE_AT_START_RST = 1'b1;
  localparam logic [COUNT_W-1:0] RESERVED_FRAMES_RST = 11'd1;

endpackage

// ===== rtl/contiguous_frame_allocator_unit.sv =====
// Contiguous frame allocator, top level.
// Input stream: in_tuser = request kind, in_tdata = frame count and frame number.
// Result stream: out_tdata = status and first frame of an allocated run.
// Configuration: APB-style port, registers base_frame, pool_size, reserve_at_start
// and reserved_frames at byte addresses 0, 4, 8 and 12; pready is always high.
// Each request gives exactly one result. The frame states sit in a one-port-read,
// one-port-write memory, and that single read port paces the work. Steps per request:
//   allocate: a scan from the pool start up to the first fitting run, then a fill of it;
//   no fit: a scan of the whole pool; release: a scan that frees the head and its tail;
//   mark: a fill of the marked range; initialize: a fill of the whole pool;
//   requests rejected at decode go straight to the result.
// The longest request is an allocate of the whole pool.
// One request is worked on at a time. A new request can be accepted as soon as the
// previous result sits in the output register, even if the receiver has not yet
// taken it; a stalled receiver holds the block only when a second result is ready.
// After reset a clearing sweep writes every entry of the memory free;
// in_tready stays low during it, configuration writes are taken as always.
module contiguous_frame_allocator_unit #(
  parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0]: frame_count [10:0], frame_number [30:11], zero [31]
  input  logic [cfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0]: req_type
  input  logic [cfa_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [23:0]: status [2:0], first_frame [22:3], zero [23]
  output logic [cfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cfa_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [cfa_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [cfa_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);

  cfg_t               cfg;
  req_t               in_req;
  logic [COUNT_W-1:0] in_count;
  logic [FRAME_W-1:0] in_frame;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [1:0]         mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [1:0]         mem_rd_data;

  // Unpack the input transfer.
  assign in_req   = req_t'(in_tuser);
  assign in_count = in_tdata[COUNT_W-1:0];
  assign in_frame = in_tdata[COUNT_W +: FRAME_W];

  cfa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cfa_state_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  cfa_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req      (in_req),
    .in_count    (in_count),
    .in_frame    (in_frame),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

// ===== rtl/cfa_cfg.sv =====
// APB-style configuration registers of the contiguous frame allocator.
// Depends on cfa_pkg for the register layout and reset values.
module cfa_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [cfa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cfa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cfa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output cfa_pkg::cfg_t             cfg
);
  import cfa_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_hit;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_hit) begin
      case (reg_idx)
        REG_BASE_FRAME:    cfg_nxt.base_frame       = cfg_pwdata[FRAME_W-1:0];
        REG_POOL_SIZE:     cfg_nxt.pool_size        = cfg_pwdata[COUNT_W-1:0];
        REG_RESERVE_START: cfg_nxt.reserve_at_start = cfg_pwdata[0];
        REG_RESERVED_CNT:  cfg_nxt.reserved_frames  = cfg_pwdata[COUNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_frame       <= BASE_FRAME_RST;
      cfg_r.pool_size        <= POOL_SIZE_RST;
      cfg_r.reserve_at_start <= RESERVE_AT_START_RST;
      cfg_r.reserved_frames  <= RESERVED_FRAMES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_BASE_FRAME:    cfg_prdata = CFG_DW'(cfg_r.base_frame);
      REG_POOL_SIZE:     cfg_prdata = CFG_DW'(cfg_r.pool_size);
      REG_RESERVE_START: cfg_prdata = CFG_DW'(cfg_r.reserve_at_start);
      REG_RESERVED_CNT:  cfg_prdata = CFG_DW'(cfg_r.reserved_frames);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/cfa_state_mem.sv =====
// Frame state memory: one write port and one read port, registered read data.
// Depends on nothing; the controller supplies all addresses.
module cfa_state_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cfa_ctrl.sv =====
// Request sequencer of the frame allocator: clearing sweep, scans, fills, result register.
// Depends on cfa_pkg and on the assertion macro header.
module cfa_ctrl #(
  parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF,
  parameter int AW         = $clog2(MAX_FRAMES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfa_pkg::cfg_t                   cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  cfa_pkg::req_t                   in_req,
  input  logic [cfa_pkg::COUNT_W-1:0]     in_count,
  input  logic [cfa_pkg::FRAME_W-1:0]     in_frame,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            mem_wr_en,
  output logic [AW-1:0]                   mem_wr_addr,
  output logic [1:0]                      mem_wr_data,
  output logic                            mem_rd_en,
  output logic [AW-1:0]                   mem_rd_addr,
  input  logic [1:0]                      mem_rd_data
);
  import cfa_pkg::*;

  `include "contiguous_frame_allocator_unit_assert.svh"

  localparam int NW = AW + 1;
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int SW = NW + MAP_SHIFT + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CLR  = 5'b00010,
    S_SCAN = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } ctl_state_t;

  ctl_state_t         state_r, state_nxt;
  logic [NW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               pv_r, pv_nxt;
  logic [NW-1:0]      pidx_r, pidx_nxt;
  logic [NW-1:0]      head_r, head_nxt;
  logic [NW-1:0]      run_r, run_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  req_t               mode_r, mode_nxt;
  logic [NW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [NW-1:0]      fill_end_r, fill_end_nxt;
  logic [NW-1:0]      split_r, split_nxt;
  fstate_t            lo_code_r, lo_code_nxt;
  fstate_t            hi_code_r, hi_code_nxt;
  logic               head_mark_r, head_mark_nxt;
  status_t            status_r, status_nxt;
  logic [FRAME_W-1:0] first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CW-1:0]      pool_ext;
  logic [NW-1:0]      n_eff;
  logic [FRAME_W:0]   diff;
  logic [FRAME_W-1:0] rel;
  logic               below;
  logic               in_pool;
  logic [FRAME_W:0]   mark_end;
  logic               mark_ok;
  logic [SW-1:0]      ceil_sum;
  logic [CW-1:0]      map_frames;
  logic [CW-1:0]      rsv_raw;
  logic [CW-1:0]      rsv_cap;
  logic [NW-1:0]      run_inc;
  logic               accept;
  logic               out_free;
  fstate_t            rd_state;

  // Effective pool size and the frame offset checks of the incoming request.
  assign pool_ext   = CW'(cfg.pool_size);
  assign n_eff      = (pool_ext > CW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(pool_ext);
  assign diff       = {1'b0, in_frame} - {1'b0, cfg.base_frame};
  assign below      = diff[FRAME_W];
  assign rel        = diff[FRAME_W-1:0];
  assign in_pool    = !below && (rel < FRAME_W'(n_eff));
  assign mark_end   = {1'b0, rel} + (FRAME_W+1)'(in_count);
  assign mark_ok    = !below && (mark_end <= (FRAME_W+1)'(n_eff));

  // Reserved frame count at initialization, capped at the pool size.
  assign ceil_sum   = SW'(n_eff) + SW'((1 << MAP_SHIFT) - 1);
  assign map_frames = CW'(ceil_sum >> MAP_SHIFT);
  always_comb begin
    if (!cfg.reserve_at_start) begin
      rsv_raw = '0;
    end else if (cfg.reserved_frames == '0) begin
      rsv_raw = map_frames;
    end else begin
      rsv_raw = CW'(cfg.reserved_frames);
    end
    rsv_cap = (rsv_raw > CW'(n_eff)) ? CW'(n_eff) : rsv_raw;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign rd_state   = fstate_t'(mem_rd_data);
  assign run_inc    = run_r + 1'b1;

  // Reads are issued only while scanning and only inside the pool.
  assign mem_rd_en   = (state_r == S_SCAN) && (rd_idx_r < n_eff);
  assign mem_rd_addr = rd_idx_r[AW-1:0];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    head_nxt      = head_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    wr_idx_nxt    = wr_idx_r;
    fill_end_nxt  = fill_end_r;
    split_nxt     = split_r;
    lo_code_nxt   = lo_code_r;
    hi_code_nxt   = hi_code_r;
    head_mark_nxt = head_mark_r;
    status_nxt    = status_r;
    first_nxt     = first_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = wr_idx_r[AW-1:0];
    mem_wr_data   = FS_FREE;

    case (state_r)
      // Sweep the whole memory to free after reset.
      S_CLR: begin
        mem_wr_en  = 1'b1;
        wr_idx_nxt = wr_idx_r + 1'b1;
        if (wr_idx_r == NW'(MAX_FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Decode a new request.
      S_IDLE: begin
        if (accept) begin
          status_nxt = STAT_OK;
          first_nxt  = '0;
          cnt_nxt    = in_count;
          mode_nxt   = in_req;
          case (in_req)
            REQ_ALLOC: begin
              if (in_count == '0) begin
                status_nxt = STAT_ZERO_COUNT;
                state_nxt  = S_DONE;
              end else begin
                rd_idx_nxt = '0;
                head_nxt   = '0;
                run_nxt    = '0;
                state_nxt  = S_SCAN;
              end
            end
            REQ_RELEASE: begin
              if (!in_pool) begin
                status_nxt = STAT_OUT_OF_POOL;
                state_nxt  = S_DONE;
              end else begin
                rd_idx_nxt = NW'(rel);
                head_nxt   = NW'(rel);
                state_nxt  = S_SCAN;
              end
            end
            REQ_MARK: begin
              if (in_count == '0) begin
                status_nxt = STAT_ZERO_COUNT;
                state_nxt  = S_DONE;
              end else if (!mark_ok) begin
                status_nxt = STAT_OUT_OF_POOL;
                state_nxt  = S_DONE;
              end else begin
                wr_idx_nxt    = NW'(rel);
                fill_end_nxt  = NW'(mark_end);
                split_nxt     = NW'(mark_end);
                lo_code_nxt   = FS_INACC;
                hi_code_nxt   = FS_INACC;
                head_mark_nxt = 1'b0;
                state_nxt     = S_FILL;
              end
            end
            default: begin
              wr_idx_nxt    = '0;
              fill_end_nxt  = n_eff;
              split_nxt     = NW'(rsv_cap);
              lo_code_nxt   = FS_ALLOC;
              hi_code_nxt   = FS_FREE;
              head_mark_nxt = 1'b0;
              state_nxt     = S_FILL;
            end
          endcase
        end
      end

      // Streaming scan: one read issued per cycle, the previous one evaluated.
      S_SCAN: begin
        if (mem_rd_en) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pidx_nxt   = rd_idx_r;
          pv_nxt     = 1'b1;
        end
        if (pv_r) begin
          if (mode_r == REQ_ALLOC) begin
            if (rd_state == FS_FREE) begin
              run_nxt = run_inc;
              if (CW'(run_inc) >= CW'(cnt_r)) begin
                wr_idx_nxt    = head_r;
                fill_end_nxt  = pidx_r + 1'b1;
                split_nxt     = pidx_r + 1'b1;
                lo_code_nxt   = FS_ALLOC;
                hi_code_nxt   = FS_ALLOC;
                head_mark_nxt = 1'b1;
                first_nxt     = cfg.base_frame + FRAME_W'(head_r);
                pv_nxt        = 1'b0;
                state_nxt     = S_FILL;
              end
            end else begin
              head_nxt = pidx_r + 1'b1;
              run_nxt  = '0;
            end
          end else begin
            // Release: the head first, then the allocated tail of the run.
            mem_wr_addr = pidx_r[AW-1:0];
            if (pidx_r == head_r) begin
              if (rd_state != FS_HEAD) begin
                status_nxt = STAT_NOT_HEAD;
                pv_nxt     = 1'b0;
                state_nxt  = S_DONE;
              end else begin
                mem_wr_en = 1'b1;
              end
            end else if (rd_state == FS_ALLOC) begin
              mem_wr_en = 1'b1;
            end else begin
              pv_nxt    = 1'b0;
              state_nxt = S_DONE;
            end
          end
        end else if (rd_idx_r >= n_eff) begin
          // Ran off the end of the pool.
          if (mode_r == REQ_ALLOC) begin
            status_nxt = STAT_NO_FIT;
          end
          state_nxt = S_DONE;
        end
      end

      // Range write: head code on a marked head, low code below the split, high code at or above.
      S_FILL: begin
        if (wr_idx_r < fill_end_r) begin
          mem_wr_en  = 1'b1;
          wr_idx_nxt = wr_idx_r + 1'b1;
          if (head_mark_r && (wr_idx_r == head_r)) begin
            mem_wr_data = FS_HEAD;
          end else if (wr_idx_r < split_r) begin
            mem_wr_data = lo_code_r;
          end else begin
            mem_wr_data = hi_code_r;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, first_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      wr_idx_r    <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    pidx_r      <= pidx_nxt;
    head_r      <= head_nxt;
    run_r       <= run_nxt;
    cnt_r       <= cnt_nxt;
    mode_r      <= mode_nxt;
    fill_end_r  <= fill_end_nxt;
    split_r     <= split_nxt;
    lo_code_r   <= lo_code_nxt;
    hi_code_r   <= hi_code_nxt;
    head_mark_r <= head_mark_nxt;
    status_r    <= status_nxt;
    first_r     <= first_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A release writes behind the read pointer, never onto it.
  `CFA_ASSERT_SAME(a_no_rw_collide, clk, rst_n, mem_rd_en && mem_wr_en,
                   mem_rd_addr != mem_wr_addr, "read and write hit one frame entry")
  // No request is taken while the clearing sweep runs.
  `CFA_ASSERT_SAME(a_clear_blocks_input, clk, rst_n, state_r == S_CLR,
                   !in_tready, "input taken during clearing sweep")
  // A finished request always reaches the output register.
  `CFA_ASSERT_NEXT(a_done_loads_result, clk, rst_n, (state_r == S_DONE) && out_free,
                   out_valid_r && (state_r == S_IDLE), "result not loaded")
  // Range writes stay below their end pointer.
  `CFA_ASSERT_SAME(a_fill_in_range, clk, rst_n, (state_r == S_FILL) && mem_wr_en,
                   wr_idx_r < fill_end_r, "fill wrote past its range")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the contiguous frame allocator: directed requests, then random
// phases under several configurations and flow-control patterns, checked against a frame map.
// Depends on cfa_pkg and contiguous_frame_allocator_unit from the rtl folder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfa_pkg::*;

  localparam int MAX_FR = MAX_FRAMES_DEF;

  typedef struct {
    status_t            status;
    logic [FRAME_W-1:0] first_frame;
  } outcome_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Predicted frame map and the register values it works under.
  fstate_t            frame_map [MAX_FR];
  logic [FRAME_W-1:0] base_q = BASE_FRAME_RST;
  logic [COUNT_W-1:0] size_q = POOL_SIZE_RST;
  logic               reserve_q = RESERVE_AT_START_RST;
  logic [COUNT_W-1:0] reserved_q = RESERVED_FRAMES_RST;

  outcome_t           outcome_q [$];
  logic [FRAME_W-1:0] live_heads [$];
  idle_mode_t         idle_mode = IDLE_NONE;
  int                 mismatch_count = 0;

  contiguous_frame_allocator_unit #(.MAX_FRAMES(MAX_FR)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Run guard in case the block stops answering.
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pool_frames();
    return (size_q > MAX_FR) ? MAX_FR : size_q;
  endfunction

  function automatic void paint(int unsigned start, int unsigned num, fstate_t code);
    for (int unsigned k = start; k < start + num; k++) begin
      if (k < MAX_FR) frame_map[k] = code;
    end
  endfunction

  // Applies one request to the frame map and returns the outcome it gives.
  function automatic outcome_t apply_request(req_t kind, logic [COUNT_W-1:0] count,
                                             logic [FRAME_W-1:0] frame);
    outcome_t        res;
    int unsigned     n, head, run, rel, cur, resv;
    bit              found;
    longint unsigned f, b;
    n = pool_frames();
    f = frame;
    b = base_q;
    res.status = STAT_OK;
    res.first_frame = '0;
    case (kind)
      REQ_ALLOC: begin
        if (count == 0) begin
          res.status = STAT_ZERO_COUNT;
        end else begin
          head = 0;
          run = 0;
          found = 1'b0;
          // First fit: the run restarts after every frame that is not free.
          for (int unsigned i = 0; i < n && !found; i++) begin
            if (frame_map[i] == FS_FREE) begin
              run++;
              if (run >= count) found = 1'b1;
            end else begin
              head = i + 1;
              run = 0;
            end
          end
          if (!found) begin
            res.status = STAT_NO_FIT;
          end else begin
            frame_map[head] = FS_HEAD;
            paint(head + 1, count - 1, FS_ALLOC);
            res.first_frame = base_q + FRAME_W'(head);
          end
        end
      end
      REQ_RELEASE: begin
        if (f < b || f >= b + n) begin
          res.status = STAT_OUT_OF_POOL;
        end else begin
          rel = f - b;
          if (frame_map[rel] != FS_HEAD) begin
            res.status = STAT_NOT_HEAD;
          end else begin
            frame_map[rel] = FS_FREE;
            cur = rel + 1;
            while (cur < n && frame_map[cur] == FS_ALLOC) begin
              frame_map[cur] = FS_FREE;
              cur++;
            end
          end
        end
      end
      REQ_MARK: begin
        if (count == 0) res.status = STAT_ZERO_COUNT;
        else if (f < b || f - b + count > n) res.status = STAT_OUT_OF_POOL;
        else paint(f - b, count, FS_INACC);
      end
      default: begin
        // Initialize; a zero reserve count means the frames the state map itself needs.
        paint(0, n, FS_FREE);
        if (reserve_q) begin
          resv = reserved_q;
          if (resv == 0) resv = (n + (1 << MAP_SHIFT) - 1) >> MAP_SHIFT;
          if (resv > n) resv = n;
          paint(0, resv, FS_ALLOC);
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Receiver side: stall pattern follows the current idle mode.
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_tready <= ($urandom_range(99) >= 87);
      IDLE_BOTH:     out_tready <= ($urandom_range(99) >= 33);
      default:       out_tready <= 1'b1;
    endcase
  end

  // Result checking: every result transfer is compared with the oldest outcome.
  always @(posedge clk) begin
    outcome_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %h", out_tdata));
      end else begin
        exp = outcome_q.pop_front();
        if (out_tdata[STATUS_W-1:0] !== exp.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_tdata[STATUS_W-1:0], exp.status));
        if (out_tdata[STATUS_W +: FRAME_W] !== exp.first_frame)
          report_mismatch($sformatf("first_frame %h, expected %h",
                                    out_tdata[STATUS_W +: FRAME_W], exp.first_frame));
      end
    end
  end

  // A setup phase, then an access phase; psel is left high for a following write.
  task automatic write_register(reg_idx_t idx, logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_BASE_FRAME:    base_q = value[FRAME_W-1:0];
      REG_POOL_SIZE:     size_q = value[COUNT_W-1:0];
      REG_RESERVE_START: reserve_q = value[0];
      default:           reserved_q = value[COUNT_W-1:0];
    endcase
  endtask

  task automatic write_registers(logic [FRAME_W-1:0] base, logic [COUNT_W-1:0] size,
                                 logic reserve, logic [COUNT_W-1:0] reserved);
    write_register(REG_BASE_FRAME, CFG_DW'(base));
    write_register(REG_POOL_SIZE, CFG_DW'(size));
    write_register(REG_RESERVE_START, CFG_DW'(reserve));
    write_register(REG_RESERVED_CNT, CFG_DW'(reserved));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Sends one request; tvalid stays high so back-to-back transfers need no reassertion.
  task automatic send_request(req_t kind, logic [COUNT_W-1:0] count,
                              logic [FRAME_W-1:0] frame);
    outcome_t res;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 33 : 87)) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {1'b0, frame, count};
    do @(posedge clk); while (!in_tready);
    res = apply_request(kind, count, frame);
    outcome_q.push_back(res);
    if (kind == REQ_ALLOC && res.status == STAT_OK) live_heads.push_back(res.first_frame);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  // Mostly well-formed traffic: small allocations, releases of live heads, short marks.
  task automatic pick_request(output req_t kind, output logic [COUNT_W-1:0] count,
                              output logic [FRAME_W-1:0] frame);
    int unsigned n, roll, k;
    n = pool_frames();
    roll = $urandom_range(99);
    count = COUNT_W'($urandom_range(1, (n > 8) ? n / 4 : 2));
    frame = base_q + FRAME_W'($urandom_range(0, n - 1));
    if (roll < 40) begin
      kind = REQ_ALLOC;
    end else if (roll < 75) begin
      kind = REQ_RELEASE;
      if (live_heads.size() != 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(live_heads.size() - 1);
        frame = live_heads[k];
        live_heads.delete(k);
      end
    end else if (roll < 92) begin
      kind = REQ_MARK;
      count = COUNT_W'($urandom_range(1, 3));
      // Range ending exactly at the pool end, or one frame past it.
      if ($urandom_range(7) == 0) frame = base_q + FRAME_W'(n - count + $urandom_range(1));
    end else begin
      kind = REQ_INIT;
    end
    if ($urandom_range(15) == 0) count = COUNT_W'($urandom);
    if ($urandom_range(15) == 0) frame = FRAME_W'($urandom);
  endtask

  // Reset state: whole pool free, default registers, no initialize needed.
  task automatic test_reset_state();
    send_request(REQ_ALLOC, 11'd1024, 20'h0);
    send_request(REQ_RELEASE, 11'd0, 20'h0);
    send_request(REQ_ALLOC, 11'd1025, 20'h0);
    wait_for_results();
  endtask

  // Decode errors, pool bounds and the wrap of the absolute frame number.
  task automatic test_edge_requests();
    logic [FRAME_W-1:0] b;
    b = 20'hFFFFC;
    write_registers(b, 11'd16, 1'b1, 11'd0);
    send_request(REQ_INIT, 11'd0, 20'h0);
    send_request(REQ_ALLOC, 11'd0, 20'h0);
    send_request(REQ_MARK, 11'd0, b);
    send_request(REQ_ALLOC, 11'd2047, 20'h0);
    send_request(REQ_ALLOC, 11'd15, 20'h0);
    send_request(REQ_ALLOC, 11'd1, 20'h0);
    send_request(REQ_RELEASE, 11'd0, b + 20'd1);
    send_request(REQ_RELEASE, 11'd0, b + 20'd1);
    send_request(REQ_RELEASE, 11'd0, b);
    send_request(REQ_RELEASE, 11'd0, b - 20'd1);
    send_request(REQ_RELEASE, 11'd0, 20'h0);
    send_request(REQ_RELEASE, 11'd2047, 20'hFFFFF);
    send_request(REQ_MARK, 11'd3, b + 20'd14);
    send_request(REQ_MARK, 11'd2, b + 20'd2);
    send_request(REQ_ALLOC, 11'd4, 20'h0);
    send_request(REQ_ALLOC, 11'd1, 20'h0);
    send_request(REQ_RELEASE, 11'd0, b + 20'd4);
    send_request(REQ_INIT, 11'd2047, 20'hFFFFF);
    wait_for_results();
  endtask

  // A reserve count above the pool size fills the whole pool.
  task automatic test_reserve_cap();
    write_registers(20'h00400, 11'd8, 1'b1, 11'd2047);
    send_request(REQ_INIT, 11'd0, 20'h0);
    send_request(REQ_ALLOC, 11'd1, 20'h0);
    send_request(REQ_RELEASE, 11'd0, 20'h00400);
    send_request(REQ_MARK, 11'd1, 20'h00407);
    wait_for_results();
  endtask

  task automatic test_random_phase(logic [FRAME_W-1:0] base, logic [COUNT_W-1:0] size,
                                   logic reserve, logic [COUNT_W-1:0] reserved,
                                   idle_mode_t mode, int items);
    req_t               kind;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] frame;
    write_registers(base, size, reserve, reserved);
    idle_mode <= mode;
    live_heads.delete();
    send_request(REQ_INIT, 11'd0, 20'h0);
    for (int i = 1; i < items; i++) begin
      // Hold off the sender until the block has drained once per phase.
      if (i == items / 2) wait_for_results();
      pick_request(kind, count, frame);
      send_request(kind, count, frame);
    end
    wait_for_results();
    idle_mode <= IDLE_NONE;
  endtask

  initial begin
    foreach (frame_map[i]) frame_map[i] = FS_FREE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_edge_requests();
    test_reserve_cap();
    test_random_phase(20'h00000, 11'd32,   1'b1, 11'd3,    IDLE_NONE,     80);
    test_random_phase(FRAME_W'($urandom), 11'd13, 1'b0, 11'd5, IDLE_SENDER, 80);
    test_random_phase(20'hFFFEB, 11'd64,   1'b1, 11'd0,    IDLE_RECEIVER, 80);
    test_random_phase(20'hFFFFF, 11'd4,    1'b1, 11'd0,    IDLE_BOTH,     70);
    test_random_phase(20'h00000, 11'd2047, 1'b0, 11'd2047, IDLE_RECEIVER, 40);
    test_random_phase(20'h12345, 11'd1024, 1'b1, 11'd1000, IDLE_SENDER,   30);
    test_random_phase(FRAME_W'($urandom), 11'd48, 1'b1, 11'd7, IDLE_BOTH, 100);
    test_random_phase(20'h00000, 11'd20,   1'b1, 11'd1,    IDLE_NONE,     100);
    wait_for_results();
    // Let any stray result from the longest request show up before the verdict.
    repeat (2 * MAX_FR + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
